// ----- rtl/hcm_pkg.sv -----
// shared types and constants of the partitioned chained hash map
`default_nettype none

package hcm_pkg;

   localparam int BUCKETS_PER_PARTITION_DEF = 256;
   localparam int PARTITIONS_DEF            = 4;
   localparam int CELLS_DEF                 = 1024;
   localparam int KEY_BITS_DEF              = 64;

   localparam logic [1:0] OP_GET   = 2'd0;
   localparam logic [1:0] OP_PUT   = 2'd1;
   localparam logic [1:0] OP_ERASE = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] flow_key;
      logic [31:0] key_hash;
      logic [1:0]  partition;
      logic [9:0]  cell_index;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [9:0] found_index;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/hcm_head_mem.sv -----
// bucket head memory: one write port, one registered read port
`default_nettype none

module hcm_head_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 11
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/hcm_cell_mem.sv -----
// cell memory: next link and key per cell, one shared address
`default_nettype none

module hcm_cell_mem #(
   parameter int CELLS    = 1024,
   parameter int CW       = 10,
   parameter int KEY_BITS = 64
) (
   input  wire logic                clock,
   input  wire logic [CW-1:0]       addr,
   input  wire logic                rd_en,
   input  wire logic                next_we,
   input  wire logic [CW:0]         next_wd,
   input  wire logic                key_we,
   input  wire logic [KEY_BITS-1:0] key_wd,
   output logic      [CW:0]         next_rd,
   output logic      [KEY_BITS-1:0] key_rd
);

   logic [CW:0]         next_mem [CELLS];
   logic [KEY_BITS-1:0] key_mem  [CELLS];
   logic [CW:0]         next_rd_ff;
   logic [KEY_BITS-1:0] key_rd_ff;

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[addr] <= next_wd;
      end
      if (key_we) begin
         key_mem[addr] <= key_wd;
      end
      if (rd_en) begin
         next_rd_ff <= next_mem[addr];
         key_rd_ff  <= key_mem[addr];
      end
   end

   assign next_rd = next_rd_ff;
   assign key_rd  = key_rd_ff;

endmodule

`default_nettype wire

// ----- rtl/partitioned_chained_hash_map.sv -----
// top level: chain walker controller around the head and cell memories
//
//   channel  direction  ports                          payload
//   req      in         req_valid, req_stall, req_data  op, key, hash, partition, cell
//   rsp      out        rsp_valid, rsp_stall, rsp_data  found, found_index
//
// an item reads its bucket head, then walks the chain with one cell memory
// read per cell visited; a put that appends behind a cell and an erase that
// removes a cell go through one further write state (S_PUT_KEY, S_ERASE_CLR).
// one item is handled at a time: req_stall is high whenever the walker is not idle.
// after reset a clearing pass over max(buckets, cells) addresses (1024 by default)
// empties heads and links; no request transfer is taken during it.
// a finished result sits in the output register; a stalled rsp holds the
// walker only when a second result is ready.
`default_nettype none

module partitioned_chained_hash_map #(
   parameter int BUCKETS_PER_PARTITION = hcm_pkg::BUCKETS_PER_PARTITION_DEF,
   parameter int PARTITIONS            = hcm_pkg::PARTITIONS_DEF,
   parameter int CELLS                 = hcm_pkg::CELLS_DEF,
   parameter int KEY_BITS              = hcm_pkg::KEY_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire hcm_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output hcm_pkg::rsp_type      rsp_data
);

   localparam int TB   = BUCKETS_PER_PARTITION * PARTITIONS;
   localparam int HAW  = (TB > 1) ? $clog2(TB) : 1;
   localparam int BLW  = $clog2(BUCKETS_PER_PARTITION);
   localparam int CW   = $clog2(CELLS);
   localparam int SW   = $clog2(CELLS + 1);
   localparam int MAXD = (TB > CELLS) ? TB : CELLS;
   localparam int CLW  = $clog2(MAXD);
   localparam int PM1  = 1 % PARTITIONS;
   localparam int PM2  = 2 % PARTITIONS;
   localparam int PM3  = 3 % PARTITIONS;

   localparam logic [2:0] S_CLEAR     = 3'd0;
   localparam logic [2:0] S_IDLE      = 3'd1;
   localparam logic [2:0] S_HEAD      = 3'd2;
   localparam logic [2:0] S_CELL      = 3'd3;
   localparam logic [2:0] S_PUT_KEY   = 3'd4;
   localparam logic [2:0] S_ERASE_CLR = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [HAW-1:0]      bucket_ff, bucket_in;
   logic [CW-1:0]       cell_ff, cell_in;
   logic                cell_bad_ff, cell_bad_in;
   logic [CW-1:0]       cur_ff, cur_in;
   logic [CW-1:0]       prev_ff, prev_in;
   logic                have_prev_ff, have_prev_in;
   logic [SW-1:0]       steps_ff, steps_in;
   logic [CLW-1:0]      clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   hcm_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic [BLW-1:0] req_low;
   logic [1:0]     req_pm;
   logic [HAW-1:0] req_bucket;

   logic           head_we, head_re;
   logic [HAW-1:0] head_waddr;
   logic [CW:0]    head_wd, head_rd;

   logic [CW-1:0]  cell_addr;
   logic           cell_re, next_we, key_we;
   logic [CW:0]    next_wd, next_rd;
   logic [KEY_BITS-1:0] key_rd;

   logic           head_ok, next_ok, out_free, last, key_hit, accept;

   // masked hash never exceeds the bucket count, so no reduction is needed
   assign req_low = BLW'(req_data.key_hash & 32'(BUCKETS_PER_PARTITION - 1));

   always_comb begin
      case (req_data.partition)
         2'd0:    req_pm = 2'd0;
         2'd1:    req_pm = 2'(PM1);
         2'd2:    req_pm = 2'(PM2);
         2'd3:    req_pm = 2'(PM3);
         default: req_pm = 2'd0;
      endcase
   end

   assign req_bucket = HAW'(32'(req_pm) * BUCKETS_PER_PARTITION + 32'(req_low));

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign head_ok   = head_rd[CW] && (32'(head_rd[CW-1:0]) < CELLS);
   assign next_ok   = next_rd[CW] && (32'(next_rd[CW-1:0]) < CELLS);
   assign last      = (steps_ff == SW'(CELLS - 1));
   assign key_hit   = (key_rd == key_ff);
   assign head_re   = accept;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      bucket_in    = bucket_ff;
      cell_in      = cell_ff;
      cell_bad_in  = cell_bad_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      steps_in     = steps_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      head_we      = 1'b0;
      head_waddr   = bucket_ff;
      head_wd      = '0;
      cell_addr    = cur_ff;
      cell_re      = 1'b0;
      next_we      = 1'b0;
      next_wd      = '0;
      key_we       = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            head_waddr = HAW'(clr_ff);
            cell_addr  = CW'(clr_ff);
            head_we    = (32'(clr_ff) < TB);
            next_we    = (32'(clr_ff) < CELLS);
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == CLW'(MAXD - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in       = req_data.op;
               key_in      = req_data.flow_key[KEY_BITS-1:0];
               bucket_in   = req_bucket;
               cell_in     = CW'(req_data.cell_index);
               cell_bad_in = (32'(req_data.cell_index) >= CELLS);
               state_in    = S_HEAD;
            end
         end
         S_HEAD: begin
            if (op_ff == hcm_pkg::OP_NOP ||
                (op_ff == hcm_pkg::OP_PUT && cell_bad_ff) ||
                (op_ff != hcm_pkg::OP_PUT && !head_ok)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  state_in     = S_IDLE;
               end
            end else if (!head_ok) begin
               // empty bucket: new cell becomes the head
               if (out_free) begin
                  head_we      = 1'b1;
                  head_wd      = {1'b1, cell_ff};
                  cell_addr    = cell_ff;
                  key_we       = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{found: 1'b1, found_index: '0};
                  state_in     = S_IDLE;
               end
            end else begin
               cur_in       = head_rd[CW-1:0];
               cell_addr    = head_rd[CW-1:0];
               cell_re      = 1'b1;
               steps_in     = '0;
               have_prev_in = 1'b0;
               state_in     = S_CELL;
            end
         end
         S_CELL: begin
            if (op_ff == hcm_pkg::OP_PUT) begin
               if (!next_ok) begin
                  next_we  = 1'b1;
                  next_wd  = {1'b1, cell_ff};
                  state_in = S_PUT_KEY;
               end else if (last) begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     state_in     = S_IDLE;
                  end
               end else begin
                  cur_in    = next_rd[CW-1:0];
                  cell_addr = next_rd[CW-1:0];
                  cell_re   = 1'b1;
                  steps_in  = steps_ff + 1'b1;
               end
            end else if (key_hit && op_ff == hcm_pkg::OP_ERASE) begin
               // unlink: predecessor or head takes over this cell's link
               if (have_prev_ff) begin
                  cell_addr = prev_ff;
                  next_we   = 1'b1;
                  next_wd   = next_rd;
               end else begin
                  head_we = 1'b1;
                  head_wd = next_rd;
               end
               state_in = S_ERASE_CLR;
            end else if (key_hit || last || !next_ok) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{found: key_hit && op_ff == hcm_pkg::OP_GET,
                                   found_index: key_hit ? 10'(cur_ff) : '0};
                  state_in     = S_IDLE;
               end
            end else begin
               prev_in      = cur_ff;
               have_prev_in = 1'b1;
               cur_in       = next_rd[CW-1:0];
               cell_addr    = next_rd[CW-1:0];
               cell_re      = 1'b1;
               steps_in     = steps_ff + 1'b1;
            end
         end
         S_PUT_KEY: begin
            if (out_free) begin
               cell_addr    = cell_ff;
               key_we       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{found: 1'b1, found_index: '0};
               state_in     = S_IDLE;
            end
         end
         S_ERASE_CLR: begin
            if (out_free) begin
               next_we      = 1'b1;
               next_wd      = '0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{found: 1'b1, found_index: '0};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      bucket_ff    <= bucket_in;
      cell_ff      <= cell_in;
      cell_bad_ff  <= cell_bad_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      have_prev_ff <= have_prev_in;
      steps_ff     <= steps_in;
      rsp_data_ff  <= rsp_data_in;
   end

   hcm_head_mem #(
      .DEPTH (TB),
      .AW    (HAW),
      .DW    (CW + 1)
   ) u_head_mem (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wd),
      .rd_en   (head_re),
      .rd_addr (req_bucket),
      .rd_data (head_rd)
   );

   hcm_cell_mem #(
      .CELLS    (CELLS),
      .CW       (CW),
      .KEY_BITS (KEY_BITS)
   ) u_cell_mem (
      .clock   (clock),
      .addr    (cell_addr),
      .rd_en   (cell_re),
      .next_we (next_we),
      .next_wd (next_wd),
      .key_we  (key_we),
      .key_wd  (key_ff),
      .next_rd (next_rd),
      .key_rd  (key_rd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_to_head: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_HEAD)
      else $error("accepted transfer did not start a head read");

   a_index_only_on_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.found || rsp_data_ff.found_index == '0))
      else $error("found_index set without found");

   a_rsp_from_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) != S_IDLE && $past(state_ff) != S_CLEAR)
      else $error("result raised outside an item");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !head_we && !next_we && !key_we)
      else $error("memory write while idle");

endmodule

`default_nettype wire
